// File: rtl/lik_pkg.sv
package lik_pkg;

  // Number of CORDIC micro-rotations in every atan2 unit (8 to 24).
  localparam int CORDIC_STAGES = 16;

  // Datapath widths.
  localparam int CW = 40;       // CORDIC x and y
  localparam int ZW = 20;       // CORDIC angle accumulator
  localparam int SQ_W = 38;     // square root remainder
  localparam int SQ_RW = 18;    // square root result
  localparam int DV_RW = 52;    // divider remainder
  localparam int DEN_W = 33;    // divider denominator, 2 * a3 * a4
  localparam int Q_W = 18;      // divider quotient

  localparam int SQ1_BITS = 18; // root bits of the first square root
  localparam int SQ2_BITS = 17; // root bits of the second square root
  localparam int DIV_BITS = 18; // quotient bits of the knee cosine divide

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Pipeline schedule: index of the register stage that holds each step.
  localparam int CORDIC_LAT = CORDIC_STAGES + 1;
  localparam int B1 = 2;
  localparam int C1 = B1 + SQ1_BITS + 1;
  localparam int CA2 = B1 + CORDIC_LAT + 1;
  localparam int E1 = B1 + imax(SQ1_BITS, CORDIC_LAT) + 1;
  localparam int B2 = E1 + 1;
  localparam int C2 = B2 + SQ2_BITS + 1;
  localparam int CA14 = B2 + CORDIC_LAT + 1;
  localparam int E2 = B2 + imax(SQ2_BITS, CORDIC_LAT) + 1;
  localparam int K6 = E2 + 1;
  localparam int B3 = K6 + 1;
  localparam int E3 = B3 + CORDIC_LAT + 1;
  localparam int OUT = E3 + 1;

  localparam logic signed [ZW-1:0] HALF_PI = 20'sd102944;
  localparam logic [Q_W-1:0] ONE_Q16 = 18'd65536;
  localparam logic signed [17:0] KNEE_OFFSET_RESET = 18'sd16685;

  typedef enum logic [1:0] {
    REG_HIP_OFFSET = 2'd0,
    REG_UPPER_LINK = 2'd1,
    REG_LOWER_LINK = 2'd2,
    REG_KNEE_OFFSET = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_CLAMP = 2'd1,
    ST_FAIL = 2'd2
  } ik_status_t;

  // Per-item context that travels down the pipeline.
  typedef struct packed {
    logic [1:0] leg;
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
    logic e_neg;
    logic zlink;
    logic num_neg;
    logic ovf;
    logic [17:0] es;
    logic signed [17:0] dk;
    logic [16:0] s;
    logic signed [ZW-1:0] a_zy;
    logic signed [ZW-1:0] a_ed;
    logic signed [ZW-1:0] a_xe;
    logic signed [ZW-1:0] a_t4;
    logic signed [ZW-1:0] a_hip;
    logic [1:0] status;
  } ctx_t;

  // atan(2^-i) in Q16, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0: r = 20'sd51472;
      5'd1: r = 20'sd30386;
      5'd2: r = 20'sd16055;
      5'd3: r = 20'sd8150;
      5'd4: r = 20'sd4091;
      5'd5: r = 20'sd2047;
      5'd6: r = 20'sd1024;
      5'd7: r = 20'sd512;
      5'd8: r = 20'sd256;
      5'd9: r = 20'sd128;
      5'd10: r = 20'sd64;
      5'd11: r = 20'sd32;
      5'd12: r = 20'sd16;
      5'd13: r = 20'sd8;
      5'd14: r = 20'sd4;
      5'd15: r = 20'sd2;
      5'd16: r = 20'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/lik_sqrt_cell.sv
module lik_sqrt_cell
  import lik_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [4:0]       bit_pos,
  input  logic [SQ_W-1:0]  rem_in,
  input  logic [SQ_RW-1:0] root_in,
  output logic [SQ_W-1:0]  rem_out,
  output logic [SQ_RW-1:0] root_out
);

  logic [5:0]      sh;
  logic [SQ_W-1:0] trial;

  // (r + 2^k)^2 - r^2 = r * 2^(k+1) + 2^(2k)
  always_comb begin
    sh = {1'b0, bit_pos} + 6'd1;
    trial = (SQ_W'(root_in) << sh) + (SQ_W'(1) << {bit_pos, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_in >= trial) begin
        rem_out <= rem_in - trial;
        root_out <= root_in | (SQ_RW'(1) << bit_pos);
      end else begin
        rem_out <= rem_in;
        root_out <= root_in;
      end
    end
  end

endmodule

// File: rtl/lik_div_cell.sv
module lik_div_cell
  import lik_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [4:0]       bit_pos,
  input  logic [DEN_W-1:0] den,
  input  logic [DV_RW-1:0] rem_in,
  input  logic [Q_W-1:0]   q_in,
  output logic [DV_RW-1:0] rem_out,
  output logic [Q_W-1:0]   q_out
);

  logic [DV_RW-1:0] trial;

  assign trial = DV_RW'(den) << bit_pos;

  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_in >= trial) begin
        rem_out <= rem_in - trial;
        q_out <= q_in | (Q_W'(1) << bit_pos);
      end else begin
        rem_out <= rem_in;
        q_out <= q_in;
      end
    end
  end

endmodule

// File: rtl/lik_cordic_cell.sv
module lik_cordic_cell
  import lik_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [4:0]           step,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  output logic signed [CW-1:0] x_out,
  output logic signed [CW-1:0] y_out,
  output logic signed [ZW-1:0] z_out
);

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;

  assign xs = x_in >>> step;
  assign ys = y_in >>> step;

  // Rotate toward the x axis; a zero y counts as non-negative.
  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[CW-1]) begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + atan_entry(step);
      end else begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - atan_entry(step);
      end
    end
  end

endmodule

// File: rtl/lik_cordic.sv
module lik_cordic
  import lik_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  output logic signed [ZW-1:0] angle
);

  logic signed [CW-1:0] xc [0:CORDIC_STAGES];
  logic signed [CW-1:0] yc [0:CORDIC_STAGES];
  logic signed [ZW-1:0] zc [0:CORDIC_STAGES];

  // Left half plane is first turned by a quarter turn.
  always_ff @(posedge clk) begin
    if (en) begin
      if (x_in[CW-1]) begin
        if (!y_in[CW-1]) begin
          xc[0] <= y_in;
          yc[0] <= -x_in;
          zc[0] <= HALF_PI;
        end else begin
          xc[0] <= -y_in;
          yc[0] <= x_in;
          zc[0] <= -HALF_PI;
        end
      end else begin
        xc[0] <= x_in;
        yc[0] <= y_in;
        zc[0] <= '0;
      end
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    lik_cordic_cell u_cell (
      .clk   (clk),
      .en    (en),
      .step  (5'(g)),
      .x_in  (xc[g]),
      .y_in  (yc[g]),
      .z_in  (zc[g]),
      .x_out (xc[g+1]),
      .y_out (yc[g+1]),
      .z_out (zc[g+1])
    );
  end

  assign angle = zc[CORDIC_STAGES];

endmodule

// File: rtl/leg_inverse_kinematics.sv
// Inverse kinematics of one three-joint leg, one foot position per item.
// The input channel carries leg_index and foot_x/y/z (Q16 metres) under
// in_valid and in_stall. The output channel carries abduction_angle,
// hip_angle and knee_angle (Q16 radians) and status under out_valid and
// out_stall. Every accepted item gives exactly one result, in order.
// The datapath is one pipeline of cells: bit-serial square root and divide
// cells (one result bit per cell) and CORDIC cells (one micro-rotation per
// cell), with each item's context traveling beside them. A new item can
// enter every cycle while the pipeline is not held by an output stall.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall rises; while the output stage is empty or drained, items
// keep flowing. Reset clears every valid bit and loads the register reset
// values. Configuration is written through cfg_valid/cfg_ready (always
// ready) and must only be written while the block holds no item.
module leg_inverse_kinematics
  import lik_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         leg_index,
  input  logic signed [17:0] foot_x,
  input  logic signed [17:0] foot_y,
  input  logic signed [17:0] foot_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [19:0] abduction_angle,
  output logic signed [19:0] hip_angle,
  output logic signed [19:0] knee_angle,
  output logic [1:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [17:0]        cfg_data
);

  // Configuration registers and values derived from them. The derived
  // values are registered in turn, the products first and then aa and den, well before any item needs them.
  logic [15:0]        hip_lateral_offset;
  logic [15:0]        upper_link_length;
  logic [15:0]        lower_link_length;
  logic signed [17:0] knee_angle_offset;
  logic [31:0]        dd;
  logic [31:0]        a3_sq;
  logic [31:0]        a4_sq;
  logic [31:0]        a3_a4;
  logic [DEN_W-1:0]   aa;
  logic [DEN_W-1:0]   den;
  logic               zlink;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hip_lateral_offset <= '0;
      upper_link_length <= '0;
      lower_link_length <= '0;
      knee_angle_offset <= KNEE_OFFSET_RESET;
      dd <= '0;
      a3_sq <= '0;
      a4_sq <= '0;
      a3_a4 <= '0;
      aa <= '0;
      den <= '0;
      zlink <= 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_HIP_OFFSET: hip_lateral_offset <= cfg_data[15:0];
          REG_UPPER_LINK: upper_link_length <= cfg_data[15:0];
          REG_LOWER_LINK: lower_link_length <= cfg_data[15:0];
          REG_KNEE_OFFSET: knee_angle_offset <= $signed(cfg_data);
        endcase
      end
      dd <= hip_lateral_offset * hip_lateral_offset;
      a3_sq <= upper_link_length * upper_link_length;
      a4_sq <= lower_link_length * lower_link_length;
      a3_a4 <= upper_link_length * lower_link_length;
      aa <= {1'b0, a3_sq} + {1'b0, a4_sq};
      den <= {a3_a4, 1'b0};
      zlink <= (upper_link_length == '0) || (lower_link_length == '0);
    end
  end

  // Handshake: the pipeline advances unless a finished result is held.
  logic en;
  logic v [0:OUT];

  assign en = !v[OUT] || !out_stall;
  assign in_stall = !en;
  assign out_valid = v[OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= OUT; k++) begin
        v[k] <= 1'b0;
      end
    end else if (en) begin
      v[0] <= in_valid;
      for (int k = 1; k <= OUT; k++) begin
        v[k] <= v[k-1];
      end
    end
  end

  // Context pipeline.
  ctx_t ctx [0:E3];
  ctx_t ctx_n [1:E3];

  // Front end: squares, the radicand E and the knee cosine numerator.
  logic signed [35:0] sq_x;
  logic signed [35:0] sq_y;
  logic signed [35:0] sq_z;
  logic [34:0]        p_xx;
  logic [34:0]        p_yy;
  logic [34:0]        p_zz;
  logic signed [36:0] e1;
  logic [34:0]        xx1;
  logic signed [37:0] num;
  logic [37:0]        nabs;
  logic               ovf;

  assign sq_x = foot_x * foot_x;
  assign sq_y = foot_y * foot_y;
  assign sq_z = foot_z * foot_z;

  always_comb begin
    num = $signed({e1[36], e1}) + $signed({3'b0, xx1}) - $signed({5'b0, aa});
    nabs = num[37] ? 38'(-num) : 38'(num);
    ovf = nabs >= {3'b0, den, 2'b0};
  end

  // Cell chain storage.
  logic [SQ_W-1:0]  sq1_rem [0:SQ1_BITS];
  logic [SQ_RW-1:0] sq1_root [0:SQ1_BITS];
  logic [DV_RW-1:0] div_rem [0:DIV_BITS];
  logic [Q_W-1:0]   div_q [0:DIV_BITS];
  logic [SQ_W-1:0]  sq2_rem [0:SQ2_BITS];
  logic [SQ_RW-1:0] sq2_root [0:SQ2_BITS];
  logic [32:0]      rad2;
  logic [32:0]      m_as;
  logic signed [34:0] m_ad;
  logic signed [35:0] x5;
  logic signed [33:0] y5;
  logic signed [35:0] dk_sq;

  assign dk_sq = ctx[E1].dk * ctx[E1].dk;

  always_ff @(posedge clk) begin
    if (en) begin
      ctx[0].leg <= leg_index;
      ctx[0].x <= foot_x;
      ctx[0].y <= foot_y;
      ctx[0].z <= foot_z;
      ctx[0].e_neg <= 1'b0;
      ctx[0].zlink <= 1'b0;
      ctx[0].num_neg <= 1'b0;
      ctx[0].ovf <= 1'b0;
      ctx[0].es <= '0;
      ctx[0].dk <= '0;
      ctx[0].s <= '0;
      ctx[0].a_zy <= '0;
      ctx[0].a_ed <= '0;
      ctx[0].a_xe <= '0;
      ctx[0].a_t4 <= '0;
      ctx[0].a_hip <= '0;
      ctx[0].status <= ST_OK;
      for (int k = 1; k <= E3; k++) begin
        ctx[k] <= ctx_n[k];
      end
      p_xx <= sq_x[34:0];
      p_yy <= sq_y[34:0];
      p_zz <= sq_z[34:0];
      e1 <= $signed({2'b0, p_yy}) + $signed({2'b0, p_zz}) - $signed({5'b0, dd});
      xx1 <= p_xx;
      // Start of the first square root and the divide.
      sq1_rem[0] <= e1[36] ? '0 : {1'b0, e1};
      sq1_root[0] <= '0;
      div_rem[0] <= ovf ? '0 : {1'b0, nabs[34:0], 16'b0};
      div_q[0] <= '0;
      // 1 - D^2 in Q32 feeds the second square root.
      rad2 <= 33'h1_0000_0000 - dk_sq[32:0];
      m_as <= lower_link_length * ctx[E2].s;
      m_ad <= $signed({1'b0, lower_link_length}) * ctx[E2].dk;
      x5 <= $signed({4'b0, upper_link_length, 16'b0}) + 36'(m_ad);
      y5 <= ctx[K6].leg[0] ? $signed({1'b0, m_as}) : -$signed({1'b0, m_as});
    end
  end

  assign sq2_rem[0] = {5'b0, rad2};
  assign sq2_root[0] = '0;

  // Square root and divide chains.
  for (genvar g = 0; g < SQ1_BITS; g++) begin : g_sq1
    lik_sqrt_cell u_sq (
      .clk      (clk),
      .en       (en),
      .bit_pos  (5'(SQ1_BITS - 1 - g)),
      .rem_in   (sq1_rem[g]),
      .root_in  (sq1_root[g]),
      .rem_out  (sq1_rem[g+1]),
      .root_out (sq1_root[g+1])
    );
  end

  for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
    lik_div_cell u_div (
      .clk     (clk),
      .en      (en),
      .bit_pos (5'(DIV_BITS - 1 - g)),
      .den     (den),
      .rem_in  (div_rem[g]),
      .q_in    (div_q[g]),
      .rem_out (div_rem[g+1]),
      .q_out   (div_q[g+1])
    );
  end

  for (genvar g = 0; g < SQ2_BITS; g++) begin : g_sq2
    lik_sqrt_cell u_sq (
      .clk      (clk),
      .en       (en),
      .bit_pos  (5'(SQ2_BITS - 1 - g)),
      .rem_in   (sq2_rem[g]),
      .root_in  (sq2_root[g]),
      .rem_out  (sq2_rem[g+1]),
      .root_out (sq2_root[g+1])
    );
  end

  // The five atan2 units.
  logic signed [ZW-1:0] ang_zy;
  logic signed [ZW-1:0] ang_ed;
  logic signed [ZW-1:0] ang_xe;
  logic signed [ZW-1:0] ang_t4;
  logic signed [ZW-1:0] ang_hip;
  logic signed [CW-1:0] d_op;

  assign d_op = ctx[B2].leg[1] ? -CW'($signed({1'b0, hip_lateral_offset}))
                               : CW'($signed({1'b0, hip_lateral_offset}));

  lik_cordic u_zy (
    .clk(clk), .en(en), .x_in(CW'(ctx[B1].y)), .y_in(CW'(ctx[B1].z)), .angle(ang_zy)
  );

  lik_cordic u_ed (
    .clk(clk), .en(en), .x_in(d_op), .y_in(CW'($signed({1'b0, ctx[B2].es}))),
    .angle(ang_ed)
  );

  lik_cordic u_xe (
    .clk(clk), .en(en), .x_in(CW'($signed({1'b0, ctx[B2].es}))),
    .y_in(-CW'(ctx[B2].x)), .angle(ang_xe)
  );

  lik_cordic u_t4 (
    .clk(clk), .en(en), .x_in(CW'(ctx[B3].dk)),
    .y_in(CW'($signed({1'b0, ctx[B3].s}))), .angle(ang_t4)
  );

  lik_cordic u_hip (
    .clk(clk), .en(en), .x_in(CW'(x5)), .y_in(CW'(y5)), .angle(ang_hip)
  );

  // Knee cosine: clamp, sign and status once the quotient is complete.
  logic [Q_W-1:0] q_fin;
  logic           q_big;
  logic [Q_W-1:0] q_mag;

  always_comb begin
    q_fin = div_q[DIV_BITS];
    q_big = ctx[C1-1].ovf || (q_fin > ONE_Q16);
    q_mag = (ctx[C1-1].zlink || q_big) ? ONE_Q16 : q_fin;
  end

  always_comb begin
    for (int k = 1; k <= E3; k++) begin
      ctx_n[k] = ctx[k-1];
    end
    ctx_n[B1].e_neg = e1[36];
    ctx_n[B1].zlink = zlink;
    ctx_n[B1].num_neg = num[37];
    ctx_n[B1].ovf = ovf;
    ctx_n[C1].es = sq1_root[SQ1_BITS];
    ctx_n[C1].dk = ctx[C1-1].num_neg ? -$signed(q_mag) : $signed(q_mag);
    if (ctx[C1-1].e_neg || ctx[C1-1].zlink) begin
      ctx_n[C1].status = ST_FAIL;
    end else if (q_big) begin
      ctx_n[C1].status = ST_CLAMP;
    end else begin
      ctx_n[C1].status = ST_OK;
    end
    ctx_n[CA2].a_zy = ang_zy;
    ctx_n[C2].s = sq2_root[SQ2_BITS][16:0];
    ctx_n[CA14].a_ed = ang_ed;
    ctx_n[CA14].a_xe = ang_xe;
    ctx_n[E3].a_t4 = ang_t4;
    ctx_n[E3].a_hip = ang_hip;
  end

  // Output stage: combine the angle terms.
  logic signed [ZW:0] th1;
  logic signed [ZW:0] th3;
  logic signed [ZW:0] t4f;

  always_comb begin
    th1 = (ZW+1)'(ctx[E3].a_ed) + (ZW+1)'(ctx[E3].a_zy);
    th3 = (ZW+1)'(ctx[E3].a_xe) - (ZW+1)'(ctx[E3].a_hip);
    t4f = (ZW+1)'(knee_angle_offset) - (ZW+1)'(ctx[E3].a_t4);
    if (ctx[E3].leg[0]) begin
      t4f = -t4f;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      abduction_angle <= th1[19:0];
      hip_angle <= th3[19:0];
      knee_angle <= t4f[19:0];
      status <= ctx[E3].status;
    end
  end

`ifndef SYNTH
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_CLAMP || status == ST_FAIL))
    else $error("undefined status code on a result");
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v[0])
    else $error("accepted item did not enter the pipeline");
`endif

endmodule

// File: test/leg_inverse_kinematics_tb.sv
`timescale 1ns / 100ps

// Testbench for the leg inverse kinematics pipeline.
// A driver pulls foot positions from a queue of pending items and offers them
// on the input channel. At each accepted item it computes the expected joint
// angles with its own fixed-point predictor and appends them to a queue.
// A monitor drains the output channel and compares every result with the
// oldest expectation. Both channels idle in short random bursts, except in
// the final phase. Registers are rewritten only between phases, once the
// pipeline has emptied.
module leg_inverse_kinematics_tb;
  import lik_pkg::*;

  localparam int LATENCY = 45 + CORDIC_STAGES;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [1:0] leg;
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
  } foot_item_t;

  typedef struct {
    logic [19:0] abd;
    logic [19:0] hip;
    logic [19:0] knee;
    ik_status_t status;
  } joint_angles_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] leg_index = '0;
  logic signed [17:0] foot_x = '0;
  logic signed [17:0] foot_y = '0;
  logic signed [17:0] foot_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [19:0] abduction_angle;
  logic signed [19:0] hip_angle;
  logic signed [19:0] knee_angle;
  logic [1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [17:0] cfg_data = '0;

  // Local copies of the configuration registers, as the predictor sees them.
  longint hip_offset_q16 = 0;
  longint upper_link_q16 = 0;
  longint lower_link_q16 = 0;
  longint knee_offset_q16 = 16685;

  foot_item_t pending_feet[$];
  joint_angles_t expected_angles[$];
  bit failed = 1'b0;
  bit idling_on = 1'b1;
  int send_gap = 0;
  int recv_gap = 0;
  int cycle_count = 0;

  leg_inverse_kinematics dut (.*);

  always #6 clk = ~clk;

  // The CORDIC angle table: atan(2^-i) in Q16, rounded to nearest.
  function automatic longint atan_step(input int i);
    longint steps[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2, 1};
    if (i > 16) return 0;
    return steps[i];
  endfunction

  function automatic longint floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // Vectoring CORDIC. Arithmetic right shifts of signed values are floor shifts.
  function automatic longint vector_angle(input longint y, input longint x);
    longint ang;
    longint t;
    longint xs;
    longint ys;
    ang = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        ang = 102944;
      end else begin
        x = -y;
        y = t;
        ang = -102944;
      end
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        ang += atan_step(i);
      end else begin
        x = x - ys;
        y = y + xs;
        ang -= atan_step(i);
      end
    end
    return ang;
  endfunction

  function automatic joint_angles_t predict_angles(input foot_item_t f);
    joint_angles_t r;
    longint x;
    longint y;
    longint z;
    longint d;
    longint e;
    longint es;
    longint num;
    longint dk;
    longint s;
    longint sn;
    longint knee;
    longint abd;
    longint hip;
    x = longint'(f.x);
    y = longint'(f.y);
    z = longint'(f.z);
    r.status = ST_OK;
    // Legs 2 and 3 sit on the other side, so the hip offset flips sign.
    d = (f.leg >= 2) ? -hip_offset_q16 : hip_offset_q16;
    e = y * y + z * z - d * d;
    if (e < 0) begin
      r.status = ST_FAIL;
      es = 0;
    end else begin
      es = floor_root(e);
    end
    abd = vector_angle(es, d) + vector_angle(z, y);
    // The raw radicand enters the knee cosine even when it was negative.
    num = e + x * x - upper_link_q16 * upper_link_q16 - lower_link_q16 * lower_link_q16;
    if (upper_link_q16 == 0 || lower_link_q16 == 0) begin
      r.status = ST_FAIL;
      dk = (num >= 0) ? 65536 : -65536;
    end else begin
      dk = (num * 65536) / (2 * upper_link_q16 * lower_link_q16);
      if (dk > 65536 || dk < -65536) begin
        if (r.status == ST_OK) r.status = ST_CLAMP;
        dk = (dk > 0) ? 65536 : -65536;
      end
    end
    s = floor_root(64'd4294967296 - dk * dk);
    knee = -vector_angle(s, dk) + knee_offset_q16;
    sn = -s;
    // Hind legs bend the other way.
    if (f.leg[0]) begin
      knee = -knee;
      sn = s;
    end
    hip = vector_angle(-x, es) -
          vector_angle(lower_link_q16 * sn, upper_link_q16 * 65536 + lower_link_q16 * dk);
    r.abd = abd[19:0];
    r.hip = hip[19:0];
    r.knee = knee[19:0];
    return r;
  endfunction

  // Driver: a valid item is held until it is accepted; gaps come in bursts.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
      in_valid <= 1'b1;
    end else begin
      if (in_valid) begin
        expected_angles.push_back(predict_angles('{leg_index, foot_x, foot_y, foot_z}));
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_feet.size() > 0) begin
        foot_item_t f;
        f = pending_feet.pop_front();
        in_valid <= 1'b1;
        leg_index <= f.leg;
        foot_x <= f.x;
        foot_y <= f.y;
        foot_z <= f.z;
        if (idling_on && $urandom_range(0, 4) == 0) send_gap <= $urandom_range(1, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: stalls the output in bursts and checks each accepted result.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_angles.size() == 0) begin
          $display("%0t: result with nothing expected: abd %0d hip %0d knee %0d status %0d",
                   $time, abduction_angle, hip_angle, knee_angle, status);
          failed = 1'b1;
        end else begin
          joint_angles_t w;
          w = expected_angles.pop_front();
          if (abduction_angle !== w.abd) begin
            $display("%0t: abduction_angle expected %0d actual %0d",
                     $time, $signed(w.abd), abduction_angle);
            failed = 1'b1;
          end
          if (hip_angle !== w.hip) begin
            $display("%0t: hip_angle expected %0d actual %0d", $time, $signed(w.hip), hip_angle);
            failed = 1'b1;
          end
          if (knee_angle !== w.knee) begin
            $display("%0t: knee_angle expected %0d actual %0d",
                     $time, $signed(w.knee), knee_angle);
            failed = 1'b1;
          end
          if (status !== w.status) begin
            $display("%0t: status expected %0d actual %0d", $time, w.status, status);
            failed = 1'b1;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        recv_gap <= $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("leg_inverse_kinematics verification failed");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [17:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_HIP_OFFSET: hip_offset_q16 = longint'(value[15:0]);
      REG_UPPER_LINK: upper_link_q16 = longint'(value[15:0]);
      REG_LOWER_LINK: lower_link_q16 = longint'(value[15:0]);
      REG_KNEE_OFFSET: knee_offset_q16 = longint'($signed(value));
    endcase
  endtask

  task automatic set_leg_geometry(input int d, input int a3, input int a4, input int koff);
    write_reg(REG_HIP_OFFSET, {2'b0, 16'(d)});
    write_reg(REG_UPPER_LINK, {2'b0, 16'(a3)});
    write_reg(REG_LOWER_LINK, {2'b0, 16'(a4)});
    write_reg(REG_KNEE_OFFSET, 18'(koff));
  endtask

  // Items are queued on the falling edge so the driver never races with them.
  task automatic queue_foot(input int leg, input int x, input int y, input int z);
    @(negedge clk);
    pending_feet.push_back('{2'(leg), 18'(x), 18'(y), 18'(z)});
  endtask

  // Blocks until every queued item has gone in and every result has come out.
  task automatic drain_pipeline();
    do @(negedge clk);
    while (pending_feet.size() != 0 || in_valid || expected_angles.size() != 0);
  endtask

  // Mostly feet near the leg's workspace; some fully random noise.
  task automatic queue_random_feet(input int count);
    int reach;
    reach = int'(upper_link_q16 + lower_link_q16 + hip_offset_q16) + 16;
    if (reach > 131071) reach = 131071;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0)
        queue_foot($urandom, $urandom, $urandom, $urandom);
      else
        queue_foot($urandom, $urandom_range(0, 2 * reach) - reach,
                   $urandom_range(0, 2 * reach) - reach, $urandom_range(0, 2 * reach) - reach);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset values: both links are zero, so every item fails, and the
    // all-zero foot hits the atan2 of the origin.
    queue_foot(0, 0, 0, 0);
    queue_foot(1, 131071, 131071, 131071);
    queue_foot(2, -131072, -131072, -131072);
    queue_foot(3, -1, 1, -1);
    drain_pipeline();
    repeat (LATENCY) @(posedge clk);

    // A typical leg: 0.1 m hip offset, 0.3 m thigh and shank.
    set_leg_geometry(6554, 19661, 19661, 16685);
    for (int leg = 0; leg < 4; leg++) begin
      queue_foot(leg, 3000, 6554, -30000);     // reachable
      queue_foot(leg, 0, 100, 100);            // negative radicand
      queue_foot(leg, 131071, 131071, -131072); // far away, cosine clamped
      queue_foot(leg, -131072, -6554, 0);
    end
    queue_foot(0, 0, 6554, 0);                 // radicand exactly zero
    drain_pipeline();

    // The sender holds off here until the pipeline has emptied.
    queue_random_feet(300);
    drain_pipeline();
    repeat (LATENCY) @(posedge clk);

    // Extremes of every register.
    set_leg_geometry(65535, 65535, 65535, -131072);
    queue_foot(0, 0, 0, 0);
    queue_foot(3, 131071, -131072, 131071);
    queue_random_feet(250);
    drain_pipeline();
    repeat (LATENCY) @(posedge clk);

    set_leg_geometry(0, 1, 65535, 131071);
    queue_random_feet(250);
    drain_pipeline();
    repeat (LATENCY) @(posedge clk);

    // A few random geometries of moderate size.
    for (int p = 0; p < 3; p++) begin
      set_leg_geometry($urandom_range(0, 12000), $urandom_range(1, 30000),
                       $urandom_range(1, 30000), $urandom);
      queue_random_feet(200);
      drain_pipeline();
      repeat (LATENCY) @(posedge clk);
    end

    // Final stretch at full rate with no idling on either side.
    set_leg_geometry(6554, 19661, 16384, 16685);
    @(negedge clk);
    idling_on = 1'b0;
    queue_random_feet(250);
    drain_pipeline();
    repeat (LATENCY + 10) @(posedge clk);

    if (!failed) begin
      $display("leg_inverse_kinematics verification clean");
    end else begin
      $display("leg_inverse_kinematics verification failed");
    end
    $finish;
  end

endmodule
